### design/tcw_pkg.sv
// Shared constants, selector codes and controller/datapath interface types for the console writer.
`timescale 1ns / 1ps

package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

   // Field widths fixed by the interface.
   localparam int ADDR_W = 11;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CHAR_W = 8;
   localparam int CELL_W = 16;

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_CURSOR    = 8'd95;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   localparam logic [CHAR_W-1:0] COLOR_RESET = 8'h07;
   localparam logic [CELL_W-1:0] CELL_RESET  = {COLOR_RESET, CH_SPACE};

   // Operation codes.
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Write address selector.
   localparam logic WA_CURSOR = 1'b0;
   localparam logic WA_INDEX  = 1'b1;

   // Write data selector.
   localparam logic [2:0] WD_CHAR  = 3'd0;
   localparam logic [2:0] WD_BLANK = 3'd1;
   localparam logic [2:0] WD_MARK  = 3'd2;
   localparam logic [2:0] WD_ZERO  = 3'd3;
   localparam logic [2:0] WD_COPY  = 3'd4;
   localparam logic [2:0] WD_SPACE = 3'd5;

   // Read address selector.
   localparam logic [1:0] RA_REQ    = 2'd0;
   localparam logic [1:0] RA_SHIFT  = 2'd1;
   localparam logic [1:0] RA_SEARCH = 2'd2;

   // Column update.
   localparam logic [2:0] COL_HOLD  = 3'd0;
   localparam logic [2:0] COL_INC   = 3'd1;
   localparam logic [2:0] COL_DEC   = 3'd2;
   localparam logic [2:0] COL_ZERO  = 3'd3;
   localparam logic [2:0] COL_INDEX = 3'd4;

   // Row update.
   localparam logic [1:0] ROW_HOLD = 2'd0;
   localparam logic [1:0] ROW_INC  = 2'd1;
   localparam logic [1:0] ROW_DEC  = 2'd2;

   // Sweep index update.
   localparam logic [1:0] IDX_HOLD  = 2'd0;
   localparam logic [1:0] IDX_CLEAR = 2'd1;
   localparam logic [1:0] IDX_INC   = 2'd2;

   typedef struct packed {
      logic       load_req;
      logic       wr_en;
      logic       wa_sel;
      logic [2:0] wd_sel;
      logic       rd_en;
      logic [1:0] ra_sel;
      logic [2:0] col_op;
      logic [1:0] row_op;
      logic [1:0] idx_op;
      logic       rsp_fire;
   } dp_cmd_type;

   typedef struct packed {
      logic new_read;
      logic new_newline;
      logic new_backspace;
      logic addr_ok;
      logic col_zero;
      logic col_last;
      logic row_zero;
      logic row_last;
      logic rdata_zero;
      logic idx_row_last;
      logic idx_copy_last;
      logic idx_cells_last;
   } dp_status_type;

endpackage

### design/text_console_writer_core.sv
// Top level of the text console writer: controller and datapath joined by command and status.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// request   start / busy            req_operation, req_char_code, req_cell_address
// response  rsp_valid (one cycle)   rsp_cell_data, rsp_cursor_row, rsp_cursor_col
// config    csr_we                  csr_text_color
//
// A request beat is taken at a rising edge with start high and busy low. A read does a
// memory read, then responds; a printable character is written, then the cursor mark. A
// backspace blanks the cursor cell and the one before it, or climbs a row and searches
// it for the first zero cell; a newline zeroes each cell to the row end, then the mark.
// A scroll reads and writes back each moved cell, then clears the last row. After reset the
// store is swept to spaces with busy high; the one-cycle response strobe cannot be held off.

module text_console_writer_core
   import tcw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [ADDR_W-1:0]   req_cell_address,
   output logic                rsp_valid,
   output logic [CELL_W-1:0]   rsp_cell_data,
   output logic [ROW_W-1:0]    rsp_cursor_row,
   output logic [COL_W-1:0]    rsp_cursor_col,
   input  logic                csr_we,
   input  logic [CHAR_W-1:0]   csr_text_color
);

   // The controller only sees decoded status; all data storage lives in the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   tcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // The datapath holds the screen memory, the cursor, the sweep index and the
   // registered response, so a finished beat stays stable while the next request starts.
   tcw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_char_code    (req_char_code),
      .req_cell_address (req_cell_address),
      .csr_we           (csr_we),
      .csr_text_color   (csr_text_color),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_cell_data    (rsp_cell_data),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_col   (rsp_cursor_col)
   );

endmodule

### design/tcw_datapath.sv
// Datapath of the console writer: screen memory, cursor, sweep index and result registers.
`timescale 1ns / 1ps

module tcw_datapath
   import tcw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_operation,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [ADDR_W-1:0]   req_cell_address,
   input  logic                csr_we,
   input  logic [CHAR_W-1:0]   csr_text_color,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   output logic                rsp_valid,
   output logic [CELL_W-1:0]   rsp_cell_data,
   output logic [ROW_W-1:0]    rsp_cursor_row,
   output logic [COL_W-1:0]    rsp_cursor_col
);

   logic [CELL_W-1:0] screen_mem [CELLS];

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [CHAR_W-1:0] color_ff;
   logic              op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [CELL_W-1:0] rdata_ff;
   logic              rsp_valid_ff;
   logic [CELL_W-1:0] rsp_data_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;

   logic [ADDR_W-1:0] cursor_addr;
   logic [ADDR_W-1:0] search_addr;
   logic [ADDR_W-1:0] waddr;
   logic [ADDR_W-1:0] raddr;
   logic [CELL_W-1:0] wdata;

   assign cursor_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign search_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(idx_ff[COL_W-1:0]);
   assign waddr = (cmd.wa_sel == WA_INDEX) ? idx_ff : cursor_addr;

   always_comb begin
      case (cmd.ra_sel)
         RA_REQ:    raddr = addr_ff;
         RA_SHIFT:  raddr = idx_ff + ADDR_W'(COLUMNS);
         RA_SEARCH: raddr = search_addr;
         default:   raddr = addr_ff;
      endcase
   end

   always_comb begin
      case (cmd.wd_sel)
         WD_CHAR:  wdata = {color_ff, char_ff};
         WD_BLANK: wdata = {color_ff, {CHAR_W{1'b0}}};
         WD_MARK:  wdata = {color_ff, CH_CURSOR};
         WD_ZERO:  wdata = '0;
         WD_COPY:  wdata = rdata_ff;
         WD_SPACE: wdata = CELL_RESET;
         default:  wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         screen_mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= screen_mem[raddr];
      end
   end

   always_comb begin
      case (cmd.col_op)
         COL_HOLD:  col_in = col_ff;
         COL_INC:   col_in = col_ff + COL_W'(1);
         COL_DEC:   col_in = col_ff - COL_W'(1);
         COL_ZERO:  col_in = '0;
         COL_INDEX: col_in = idx_ff[COL_W-1:0];
         default:   col_in = col_ff;
      endcase
      case (cmd.row_op)
         ROW_HOLD: row_in = row_ff;
         ROW_INC:  row_in = row_ff + ROW_W'(1);
         ROW_DEC:  row_in = row_ff - ROW_W'(1);
         default:  row_in = row_ff;
      endcase
      case (cmd.idx_op)
         IDX_HOLD:  idx_in = idx_ff;
         IDX_CLEAR: idx_in = '0;
         IDX_INC:   idx_in = idx_ff + ADDR_W'(1);
         default:   idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         idx_ff       <= '0;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= cmd.rsp_fire;
         if (csr_we) begin
            color_ff <= csr_text_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_operation;
         char_ff <= req_char_code;
         addr_ff <= req_cell_address;
      end
      if (cmd.rsp_fire) begin
         rsp_data_ff <= (op_ff == OP_READ && status.addr_ok) ? rdata_ff : '0;
         rsp_row_ff  <= row_ff;
         rsp_col_ff  <= col_ff;
      end
   end

   always_comb begin
      status.new_read       = (req_operation == OP_READ);
      status.new_newline    = (req_char_code == CH_NEWLINE);
      status.new_backspace  = (req_char_code == CH_BACKSPACE);
      status.addr_ok        = (addr_ff < ADDR_W'(CELLS));
      status.col_zero       = (col_ff == '0);
      status.col_last       = (col_ff == COL_W'(COLUMNS - 1));
      status.row_zero       = (row_ff == '0);
      status.row_last       = (row_ff == ROW_W'(ROWS - 1));
      status.rdata_zero     = (rdata_ff == '0);
      status.idx_row_last   = (idx_ff == ADDR_W'(COLUMNS - 1));
      status.idx_copy_last  = (idx_ff == ADDR_W'(COPY_CELLS - 1));
      status.idx_cells_last = (idx_ff == ADDR_W'(CELLS - 1));
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_data  = rsp_data_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;

endmodule

### design/tcw_ctrl.sv
// Controller state machine of the console writer: sequences memory sweeps and cursor moves.
`timescale 1ns / 1ps

module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_READ     = 4'd2;
   localparam logic [3:0] S_READ_OUT = 4'd3;
   localparam logic [3:0] S_CHAR     = 4'd4;
   localparam logic [3:0] S_NL       = 4'd5;
   localparam logic [3:0] S_BS_HERE  = 4'd6;
   localparam logic [3:0] S_BS_PREV  = 4'd7;
   localparam logic [3:0] S_SRCH_RD  = 4'd8;
   localparam logic [3:0] S_SRCH_CHK = 4'd9;
   localparam logic [3:0] S_SCR_RD   = 4'd10;
   localparam logic [3:0] S_SCR_WR   = 4'd11;
   localparam logic [3:0] S_SCR_CLR  = 4'd12;
   localparam logic [3:0] S_CURSOR   = 4'd13;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.wa_sel   = WA_CURSOR;
      cmd.wd_sel   = WD_ZERO;
      cmd.ra_sel   = RA_REQ;
      cmd.col_op   = COL_HOLD;
      cmd.row_op   = ROW_HOLD;
      cmd.idx_op   = IDX_HOLD;
      case (state_ff)
         S_INIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_INDEX;
            cmd.wd_sel = WD_SPACE;
            cmd.idx_op = IDX_INC;
            if (status.idx_cells_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               if (status.new_read) begin
                  state_in = S_READ;
               end else if (status.new_newline) begin
                  state_in = S_NL;
               end else if (status.new_backspace) begin
                  state_in = S_BS_HERE;
               end else begin
                  state_in = S_CHAR;
               end
            end
         end
         S_READ: begin
            cmd.rd_en  = status.addr_ok;
            cmd.ra_sel = RA_REQ;
            state_in   = S_READ_OUT;
         end
         S_READ_OUT: begin
            cmd.rsp_fire = 1'b1;
            state_in     = S_IDLE;
         end
         S_CHAR, S_NL: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_CURSOR;
            cmd.wd_sel = (state_ff == S_CHAR) ? WD_CHAR : WD_ZERO;
            if (status.col_last) begin
               cmd.col_op = COL_ZERO;
               if (status.row_last) begin
                  cmd.idx_op = IDX_CLEAR;
                  state_in   = S_SCR_RD;
               end else begin
                  cmd.row_op = ROW_INC;
                  state_in   = S_CURSOR;
               end
            end else begin
               cmd.col_op = COL_INC;
               if (state_ff == S_CHAR) begin
                  state_in = S_CURSOR;
               end
            end
         end
         S_BS_HERE: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_CURSOR;
            cmd.wd_sel = WD_BLANK;
            if (!status.col_zero) begin
               cmd.col_op = COL_DEC;
               state_in   = S_BS_PREV;
            end else if (!status.row_zero) begin
               cmd.row_op = ROW_DEC;
               cmd.idx_op = IDX_CLEAR;
               state_in   = S_SRCH_RD;
            end else begin
               state_in = S_CURSOR;
            end
         end
         S_BS_PREV: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_CURSOR;
            cmd.wd_sel = WD_BLANK;
            state_in   = S_CURSOR;
         end
         S_SRCH_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.ra_sel = RA_SEARCH;
            state_in   = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            // Without a zero cell the index ends on the last column anyway.
            if (status.rdata_zero || status.idx_row_last) begin
               cmd.col_op = COL_INDEX;
               state_in   = S_CURSOR;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SRCH_RD;
            end
         end
         S_SCR_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.ra_sel = RA_SHIFT;
            state_in   = S_SCR_WR;
         end
         S_SCR_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_INDEX;
            cmd.wd_sel = WD_COPY;
            cmd.idx_op = IDX_INC;
            state_in   = status.idx_copy_last ? S_SCR_CLR : S_SCR_RD;
         end
         S_SCR_CLR: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_INDEX;
            cmd.wd_sel = WD_ZERO;
            cmd.idx_op = IDX_INC;
            if (status.idx_cells_last) begin
               state_in = S_CURSOR;
            end
         end
         S_CURSOR: begin
            cmd.wr_en    = 1'b1;
            cmd.wa_sel   = WA_CURSOR;
            cmd.wd_sel   = WD_MARK;
            cmd.rsp_fire = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### design/tcw_checker.sv
// Port-level checks for the console writer, bound to the top level.
`timescale 1ns / 1ps

module tcw_checker
   import tcw_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic [ROW_W-1:0] rsp_cursor_row,
   input logic [COL_W-1:0] rsp_cursor_col
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in progress");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_row < ROW_W'(ROWS)) && (rsp_cursor_col < COL_W'(COLUMNS)))
      else $error("cursor outside the screen");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_cursor_row (rsp_cursor_row),
   .rsp_cursor_col (rsp_cursor_col)
);
